FILE: hdl/fixed_block_pool_allocator_core_macros.svh
// Assertion macros for the block pool allocator.
// Empty bodies when SYNTHESIS is defined.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_CORE_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/fbpa_pkg.sv
package fbpa_pkg;

	localparam int SIZE_W   = 13;
	localparam int COUNT_W  = 11;
	localparam int SLOT_W   = 10;
	localparam int OFF_W    = 22;
	localparam int STATUS_W = 3;
	localparam int DIV_CNT_W = $clog2(OFF_W + 1);

	localparam int IN_TDATA_W  = ((OFF_W + 7) / 8) * 8;
	localparam int OUT_FIELD_W = SLOT_W + OFF_W + COUNT_W;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

	localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(4);
	localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1024);

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_EMPTY      = 3'd1,
		ST_MISALIGNED = 3'd2,
		ST_RANGE      = 3'd3,
		ST_NONE_USED  = 3'd4
	} status_t;

	typedef enum logic {
		OP_ALLOC   = 1'b0,
		OP_RELEASE = 1'b1
	} opcode_t;

	typedef enum logic {
		REG_BLOCK_SIZE  = 1'b0,
		REG_BLOCK_COUNT = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic    capture;
		logic    mem_rd;
		logic    alloc_commit;
		logic    div_start;
		logic    div_step;
		logic    rel_commit;
		logic    load_out;
		status_t status;
	} ctl_cmd_t;

	typedef struct packed {
		logic release_op;
		logic empty;
		logic none_used;
		logic div_last;
		logic misaligned;
		logic out_of_range;
	} dp_stat_t;

endpackage

FILE: hdl/fbpa_ram.sv
module fbpa_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/fbpa_ctrl.sv
module fbpa_ctrl
	import fbpa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_A_IDX,
		S_R_DIV,
		S_R_CHK,
		S_RESULT
	} state_t;

	state_t  state_q, state_d;
	status_t status_q, status_d;
	logic    out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		status_d = status_q;
		cmd = '0;
		cmd.status = status_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (stat.release_op) begin
					if (stat.none_used) begin
						status_d = ST_NONE_USED;
						state_d  = S_RESULT;
					end else begin
						cmd.div_start = 1'b1;
						state_d = S_R_DIV;
					end
				end else begin
					if (stat.empty) begin
						status_d = ST_EMPTY;
						state_d  = S_RESULT;
					end else begin
						cmd.mem_rd = 1'b1;
						state_d = S_A_IDX;
					end
				end
			end
			S_A_IDX: begin
				cmd.alloc_commit = 1'b1;
				status_d = ST_OK;
				state_d  = S_RESULT;
			end
			S_R_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = S_R_CHK;
				end
			end
			S_R_CHK: begin
				if (stat.misaligned) begin
					status_d = ST_MISALIGNED;
				end else if (stat.out_of_range) begin
					status_d = ST_RANGE;
				end else begin
					cmd.rel_commit = 1'b1;
					status_d = ST_OK;
				end
				state_d = S_RESULT;
			end
			S_RESULT: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			status_q    <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hdl/fbpa_dp.sv
module fbpa_dp
	import fbpa_pkg::*;
#(
	parameter int MAX_BLOCKS     = 1024,
	parameter int MAX_BLOCK_SIZE = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr,
	input  reg_index_t          cfg_index,
	input  logic [SIZE_W-1:0]   cfg_data,
	input  opcode_t             in_opcode,
	input  logic [OFF_W-1:0]    in_offset,
	input  ctl_cmd_t            cmd,
	output dp_stat_t            stat,
	output status_t             out_status,
	output logic [SLOT_W-1:0]   out_slot,
	output logic [OFF_W-1:0]    out_offset,
	output logic [COUNT_W-1:0]  out_used
);

	localparam int AW = $clog2(MAX_BLOCKS);

	logic [SIZE_W-1:0]  blk_size_q;
	logic [COUNT_W-1:0] blk_count_q;
	logic [SIZE_W-1:0]  eff_size;
	logic [COUNT_W-1:0] eff_count;

	opcode_t            op_q;
	logic [OFF_W-1:0]   offset_q;
	logic [SIZE_W-1:0]  size_q;
	logic [COUNT_W-1:0] count_q;

	// used_q doubles as the stack pointer; hwm_q marks how far the stack was ever popped
	logic [COUNT_W-1:0] used_q;
	logic [COUNT_W-1:0] hwm_q;

	logic [SIZE_W-1:0]    rem_q;
	logic [OFF_W-1:0]     quot_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [SIZE_W:0]      div_trial;
	logic [SIZE_W:0]      div_diff;
	logic                 div_ge;

	logic [SLOT_W-1:0]        rd_data;
	logic [SLOT_W-1:0]        sel_idx;
	logic [SLOT_W+SIZE_W-1:0] prod;

	logic [SLOT_W-1:0] res_slot_q;
	logic [OFF_W-1:0]  res_off_q;

	always_comb begin
		eff_size = blk_size_q;
		if (blk_size_q == '0) begin
			eff_size = SIZE_W'(1);
		end else if (32'(blk_size_q) > MAX_BLOCK_SIZE) begin
			eff_size = SIZE_W'(MAX_BLOCK_SIZE);
		end
		eff_count = blk_count_q;
		if (blk_count_q == '0) begin
			eff_count = COUNT_W'(1);
		end else if (32'(blk_count_q) > MAX_BLOCKS) begin
			eff_count = COUNT_W'(MAX_BLOCKS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_size_q  <= SIZE_RESET;
			blk_count_q <= COUNT_RESET;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_BLOCK_SIZE:  blk_size_q  <= cfg_data;
				REG_BLOCK_COUNT: blk_count_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// one restoring quotient bit per step
	assign div_trial = {rem_q, quot_q[OFF_W-1]};
	assign div_diff  = div_trial - {1'b0, size_q};
	assign div_ge    = (div_trial >= {1'b0, size_q});

	// slots never reached by a pop still hold their reset identity
	assign sel_idx = (used_q == hwm_q) ? used_q[SLOT_W-1:0] : rd_data;
	assign prod    = (SLOT_W + SIZE_W)'(sel_idx) * (SLOT_W + SIZE_W)'(size_q);

	fbpa_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (MAX_BLOCKS)
	) u_stack (
		.clk   (clk),
		.we    (cmd.rel_commit),
		.waddr (AW'(used_q - COUNT_W'(1))),
		.wdata (quot_q[SLOT_W-1:0]),
		.re    (cmd.mem_rd),
		.raddr (AW'(used_q)),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			hwm_q     <= '0;
			div_cnt_q <= '0;
		end else begin
			if (cmd.alloc_commit) begin
				used_q <= used_q + COUNT_W'(1);
				if (used_q == hwm_q) begin
					hwm_q <= hwm_q + COUNT_W'(1);
				end
			end else if (cmd.rel_commit) begin
				used_q <= used_q - COUNT_W'(1);
			end
			if (cmd.div_start) begin
				div_cnt_q <= DIV_CNT_W'(OFF_W);
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= in_opcode;
			offset_q <= in_offset;
			size_q   <= eff_size;
			count_q  <= eff_count;
		end
		if (cmd.div_start) begin
			rem_q  <= '0;
			quot_q <= offset_q;
		end else if (cmd.div_step) begin
			rem_q  <= div_ge ? div_diff[SIZE_W-1:0] : div_trial[SIZE_W-1:0];
			quot_q <= {quot_q[OFF_W-2:0], div_ge};
		end
		if (cmd.alloc_commit) begin
			res_slot_q <= sel_idx;
			res_off_q  <= prod[OFF_W-1:0];
		end else if (cmd.rel_commit) begin
			res_slot_q <= quot_q[SLOT_W-1:0];
			res_off_q  <= offset_q;
		end
		if (cmd.load_out) begin
			out_status <= cmd.status;
			out_used   <= used_q;
			if (cmd.status == ST_OK) begin
				out_slot   <= res_slot_q;
				out_offset <= res_off_q;
			end else begin
				out_slot   <= '0;
				out_offset <= '0;
			end
		end
	end

	always_comb begin
		stat.release_op   = (op_q == OP_RELEASE);
		stat.empty        = (used_q >= count_q);
		stat.none_used    = (used_q == '0);
		stat.div_last     = (div_cnt_q == DIV_CNT_W'(1));
		stat.misaligned   = (rem_q != '0);
		stat.out_of_range = (quot_q >= OFF_W'(count_q));
	end

endmodule

FILE: hdl/fixed_block_pool_allocator_core.sv
// Fixed-size block pool allocator: a free-list stack of slot indices.
// Input channel s_axis: tuser carries the opcode (allocate or release),
// tdata the byte offset of the block being released.
// Output channel m_axis: tuser carries the status, tdata the slot index,
// byte offset and the used count after the request.
// Config channel cfg: index 0 writes block_size, index 1 writes block_count;
// write only while no request is in flight.
// One request is worked on at a time. From accept to result valid,
// an allocate does a stack read, then index select and offset multiply;
// a release runs the bit-serial offset divider; error answers found
// before any stack or divider work skip both. A new request is taken
// once the block is back in idle after the result is loaded.
// The result sits in an output register: if m_axis_tready is low the
// block still takes the next request and computes it, then holds it until
// the register frees up.
// Reset empties the pool (used count zero, stack in identity order) and
// restores block_size 4, block_count 1024; no clearing pass is needed.
`include "fixed_block_pool_allocator_core_macros.svh"

module fixed_block_pool_allocator_core
	import fbpa_pkg::*;
#(
	parameter int MAX_BLOCKS     = 1024,
	parameter int MAX_BLOCK_SIZE = 4096
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // release_offset[21:0], zero pad
	input  logic [0:0]             s_axis_tuser,  // opcode
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // slot_index, byte_offset, used_count, pad
	output logic [STATUS_W-1:0]    m_axis_tuser,  // status
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [0:0]             cfg_index,
	input  logic [SIZE_W-1:0]      cfg_data
);

	ctl_cmd_t           cmd;
	dp_stat_t           stat;
	status_t            out_status;
	logic [SLOT_W-1:0]  out_slot;
	logic [OFF_W-1:0]   out_offset;
	logic [COUNT_W-1:0] out_used;

	assign cfg_ready = 1'b1;

	fbpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	fbpa_dp #(
		.MAX_BLOCKS     (MAX_BLOCKS),
		.MAX_BLOCK_SIZE (MAX_BLOCK_SIZE)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr     (cfg_valid & cfg_ready),
		.cfg_index  (reg_index_t'(cfg_index)),
		.cfg_data   (cfg_data),
		.in_opcode  (opcode_t'(s_axis_tuser)),
		.in_offset  (s_axis_tdata[OFF_W-1:0]),
		.cmd        (cmd),
		.stat       (stat),
		.out_status (out_status),
		.out_slot   (out_slot),
		.out_offset (out_offset),
		.out_used   (out_used)
	);

	assign m_axis_tuser = out_status;
	assign m_axis_tdata = {(OUT_TDATA_W - OUT_FIELD_W)'(0), out_used, out_offset, out_slot};

	`ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`ASSERT_IMPLY(a_err_zero_payload, clk, arst_n, m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tdata[SLOT_W+OFF_W-1:0] == '0)
	`ASSERT_IMPLY(a_used_bound, clk, arst_n, m_axis_tvalid, 32'(out_used) <= MAX_BLOCKS)

endmodule
